// ===== design/wdp_pkg.sv =====
// wdp_pkg: shared types, codes and constants of the weighted draw block.
// No dependencies; used by every module of the block except wdp_ram.
package wdp_pkg;

   localparam logic [63:0] RNG_MUL  = 64'h2545F4914F6CDD1D;
   localparam logic [63:0] RNG_SEED = 64'h9E3779B97F4A7C15;
   localparam int XS_A = 12;
   localparam int XS_B = 25;
   localparam int XS_C = 27;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic [2:0] STS_DRAWN = 3'd0;
   localparam logic [2:0] STS_ADDED = 3'd1;
   localparam logic [2:0] STS_ZERO  = 3'd2;
   localparam logic [2:0] STS_FULL  = 3'd3;
   localparam logic [2:0] STS_EMPTY = 3'd4;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PITY_THRESHOLD  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITY_MIN_RARITY = 8'd1;

   localparam int TDATA_IN_W  = 136;
   localparam int TDATA_OUT_W = 176;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SUM   = 7'b0000010,
      S_SETUP = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_PICK  = 7'b0100000,
      S_FIN   = 7'b1000000
   } fsm_type;

   typedef struct packed {
      logic load;
      logic sum_start;
      logic setup;
      logic mul_run;
      logic div_run;
      logic pick_start;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_done;
      logic mul_done;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic logic [63:0] xorshift(input logic [63:0] s_in);
      logic [63:0] s;
      s = (s_in == 64'd0) ? RNG_SEED : s_in;
      s = s ^ (s >> XS_A);
      s = s ^ (s << XS_B);
      s = s ^ (s >> XS_C);
      return s;
   endfunction

   function automatic logic pity_due(input logic [31:0] miss, input logic [31:0] thr);
      return ({1'b0, miss} + 33'd1) >= {1'b0, thr};
   endfunction

   function automatic logic [31:0] left_before(input logic [31:0] miss,
                                               input logic [31:0] thr);
      logic [31:0] r;
      if (thr == 32'd0) r = '1;
      else if (pity_due(miss, thr)) r = 32'd0;
      else r = thr - 32'd1 - miss;
      return r;
   endfunction

endpackage

// ===== design/wdp_ram.sv =====
// wdp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/wdp_ctrl.sv =====
// wdp_ctrl: sequencing state machine of the weighted draw block.
// Depends on wdp_pkg; drives the datapath through cmd_type, reads sts_type.
module wdp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tuser,
   output logic             req_tready,
   input  wdp_pkg::sts_type sts,
   output wdp_pkg::cmd_type cmd
);
   import wdp_pkg::*;

   fsm_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tuser == CMD_DRAW && !sts.empty) begin
                  cmd.sum_start = 1'b1;
                  state_in      = S_SUM;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SUM: begin
            if (sts.scan_done) state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul_run = 1'b1;
            if (sts.mul_done) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (sts.div_done) begin
               cmd.pick_start = 1'b1;
               state_in       = S_PICK;
            end
         end
         S_PICK: begin
            if (sts.scan_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
endmodule

// ===== design/wdp_dp.sv =====
// wdp_dp: datapath of the weighted draw block: table RAMs, scan, generator,
// shared 32x32 multiplier, bit-serial remainder unit and result register.
// Depends on wdp_pkg and wdp_ram.
module wdp_dp #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wdp_pkg::cmd_type                   cmd,
   output wdp_pkg::sts_type                   sts,
   input  logic                               req_tuser,
   input  logic [wdp_pkg::TDATA_IN_W-1:0]     req_tdata,
   input  logic                               csr_we,
   input  logic [wdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                        csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [2:0]                         rsp_tuser,
   output logic [wdp_pkg::TDATA_OUT_W-1:0]    rsp_tdata
);
   import wdp_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int TOT_W = 32 + $clog2(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   // latched item
   logic        cmd_ff;
   logic [31:0] id_ff, wt_ff;
   logic [7:0]  rar_ff;
   logic [63:0] rng_ff;

   // table state and config
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [31:0]      miss_ff, miss_in, seq_ff, seq_in;
   logic [31:0]      thr_ff;
   logic [7:0]       minr_ff;

   // scan
   logic [IDX_W-1:0] addr_ff;
   logic             go_ff, rvld_ff, pick_ff, hit_ff;
   logic [TOT_W-1:0] rare_ff, cum_ff, cum_next;
   logic [31:0]      pid_ff;
   logic [7:0]       prar_ff;
   logic [31:0]      id_rd;
   logic [39:0]      wr_rd;
   logic [31:0]      w_rd;
   logic [7:0]       r_rd;
   logic             rare_rd, take_rd;

   // generator, multiplier, divider
   logic             force_ff;
   logic [TOT_W-1:0] tot_sel_ff;
   logic [63:0]      s_ff, macc_ff, macc_next, prod;
   logic [31:0]      mul_a, mul_b;
   logic [1:0]       mstep_ff;
   logic [63:0]      dvd_ff;
   logic [TOT_W-1:0] rem_ff;
   logic [TOT_W:0]   dtrial, ddiff;
   logic [5:0]       dcnt_ff;

   // result
   logic             rsp_vld_ff;
   logic [2:0]       rsp_sts_ff, sts_in;
   logic [TDATA_OUT_W-1:0] rsp_data_ff, data_in;
   logic             ram_we;

   wdp_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_id_ram (
      .clock(clock), .we(ram_we), .waddr(cnt_ff[IDX_W-1:0]), .wdata(id_ff),
      .raddr(addr_ff), .rdata(id_rd)
   );

   wdp_ram #(.WIDTH(40), .DEPTH(MAX_ENTRIES)) u_wr_ram (
      .clock(clock), .we(ram_we), .waddr(cnt_ff[IDX_W-1:0]), .wdata({rar_ff, wt_ff}),
      .raddr(addr_ff), .rdata(wr_rd)
   );

   assign w_rd     = wr_rd[31:0];
   assign r_rd     = wr_rd[39:32];
   assign rare_rd  = (r_rd >= minr_ff);
   assign take_rd  = rvld_ff && !hit_ff && (!force_ff || rare_rd);
   assign cum_next = cum_ff + TOT_W'(w_rd);

   assign mul_a     = (mstep_ff == 2'd1) ? s_ff[63:32] : s_ff[31:0];
   assign mul_b     = (mstep_ff == 2'd2) ? RNG_MUL[63:32] : RNG_MUL[31:0];
   assign prod      = 64'(mul_a) * 64'(mul_b);
   assign macc_next = (mstep_ff == 2'd0) ? prod : macc_ff + {prod[31:0], 32'd0};

   assign dtrial = {rem_ff, dvd_ff[63]};
   assign ddiff  = dtrial - {1'b0, tot_sel_ff};

   assign sts.empty     = (cnt_ff == '0);
   assign sts.scan_done = hit_ff || (!go_ff && !rvld_ff);
   assign sts.mul_done  = (mstep_ff == 2'd2);
   assign sts.div_done  = (dcnt_ff == 6'd63);
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

   always_comb begin
      cnt_in   = cnt_ff;
      total_in = total_ff;
      miss_in  = miss_ff;
      seq_in   = seq_ff;
      ram_we   = 1'b0;
      sts_in   = STS_DRAWN;
      data_in  = '0;
      if (cmd_ff == CMD_ADD) begin
         if (wt_ff == 32'd0) begin
            sts_in = STS_ZERO;
         end else if (cnt_ff == MAX_CNT) begin
            sts_in = STS_FULL;
         end else begin
            sts_in   = STS_ADDED;
            ram_we   = cmd.commit;
            cnt_in   = cnt_ff + 1'b1;
            total_in = total_ff + TOT_W'(wt_ff);
         end
         data_in[168:137] = left_before(miss_ff, thr_ff);
      end else if (cnt_ff == '0) begin
         sts_in           = STS_EMPTY;
         data_in[136:73]  = rng_ff;
         data_in[168:137] = left_before(miss_ff, thr_ff);
      end else begin
         if (thr_ff != 32'd0) begin
            miss_in = (prar_ff >= minr_ff) ? 32'd0 : miss_ff + 32'd1;
         end
         seq_in           = seq_ff + 32'd1;
         data_in[31:0]    = pid_ff;
         data_in[39:32]   = prar_ff;
         data_in[40]      = force_ff;
         data_in[72:41]   = seq_ff;
         data_in[136:73]  = s_ff;
         data_in[168:137] = left_before(miss_in, thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         total_ff   <= '0;
         miss_ff    <= '0;
         seq_ff     <= '0;
         thr_ff     <= '0;
         minr_ff    <= '0;
         go_ff      <= 1'b0;
         rvld_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_PITY_THRESHOLD) thr_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_PITY_MIN_RARITY) minr_ff <= csr_wdata[7:0];

         rvld_ff <= go_ff;
         if (cmd.sum_start || cmd.pick_start) begin
            go_ff  <= 1'b1;
            hit_ff <= 1'b0;
         end else begin
            if ((go_ff && CNT_W'(addr_ff) == cnt_ff - 1'b1)
                || (pick_ff && take_rd && rem_ff < cum_next)) begin
               go_ff <= 1'b0;
            end
            if (pick_ff && take_rd && rem_ff < cum_next) hit_ff <= 1'b1;
         end

         if (cmd.commit) begin
            cnt_ff     <= cnt_in;
            total_ff   <= total_in;
            miss_ff    <= miss_in;
            seq_ff     <= seq_in;
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_tuser;
         id_ff  <= req_tdata[31:0];
         wt_ff  <= req_tdata[63:32];
         rar_ff <= req_tdata[71:64];
         rng_ff <= req_tdata[135:72];
      end

      if (cmd.sum_start || cmd.pick_start) begin
         addr_ff <= '0;
         pick_ff <= cmd.pick_start;
         cum_ff  <= '0;
         if (cmd.sum_start) rare_ff <= '0;
      end else begin
         if (go_ff) addr_ff <= addr_ff + 1'b1;
         if (!pick_ff && rvld_ff && rare_rd) rare_ff <= rare_ff + TOT_W'(w_rd);
         if (pick_ff && take_rd) begin
            cum_ff <= cum_next;
            if (rem_ff < cum_next) begin
               pid_ff  <= id_rd;
               prar_ff <= r_rd;
            end
         end
      end

      if (cmd.setup) begin
         force_ff   <= (thr_ff != 32'd0) && pity_due(miss_ff, thr_ff) && (rare_ff != '0);
         tot_sel_ff <= ((thr_ff != 32'd0) && pity_due(miss_ff, thr_ff) && (rare_ff != '0))
                       ? rare_ff : total_ff;
         s_ff       <= xorshift(rng_ff);
         mstep_ff   <= 2'd0;
      end

      if (cmd.mul_run) begin
         macc_ff  <= macc_next;
         mstep_ff <= mstep_ff + 2'd1;
         if (mstep_ff == 2'd2) begin
            dvd_ff  <= macc_next;
            rem_ff  <= '0;
            dcnt_ff <= 6'd0;
         end
      end

      if (cmd.div_run) begin
         rem_ff  <= ddiff[TOT_W] ? dtrial[TOT_W-1:0] : ddiff[TOT_W-1:0];
         dvd_ff  <= {dvd_ff[62:0], 1'b0};
         dcnt_ff <= dcnt_ff + 6'd1;
      end

      if (cmd.commit) begin
         rsp_sts_ff  <= sts_in;
         rsp_data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// ===== design/weighted_draw_with_pity.sv =====
// weighted_draw_with_pity: top level, joins controller and datapath.
// Depends on wdp_pkg, wdp_ctrl, wdp_dp (and wdp_ram through the datapath).
//
// Usage: items enter on the req_ stream (tuser = cmd: 0 add entry, 1 draw),
// one result beat per item leaves on the rsp_ stream (tuser = status).
// Registers are written on the csr_ channel (index 0 pity threshold,
// index 1 least rare rarity), always ready; the user must write them only
// while the block is idle, and the block itself does not enforce this.
// One item is in work at a time; req_tready is high only when idle.
// An add or a draw on an empty table skips the scans and goes straight to
// the result commit. A draw runs a rarity sum scan, a generator step, three
// 32x32 partial products, a bit-serial remainder over 64 dividend bits, a
// cumulative scan stopping at the pick and the result commit, all through
// one RAM read port.
// The result sits in an output register; a stalled receiver holds it and
// the next item is accepted, but its result waits until the register frees.
// Reset (synchronous) empties the table and clears the counters and registers;
// table RAM contents are not cleared and need no clearing pass.
module weighted_draw_with_pity #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // cmd
   // entry_id, entry_weight, entry_rarity, rng_in
   input  logic [wdp_pkg::TDATA_IN_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2:0]                          rsp_tuser,  // status
   // picked_id, picked_rarity, pity_forced, draw_number, rng_out, draws_left, pad
   output logic [wdp_pkg::TDATA_OUT_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wdp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);
   import wdp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   wdp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tuser(req_tuser), .req_tready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   wdp_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free) else $error("result committed over pending beat");

   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready) else $error("accepted while busy");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.setup, cmd.pick_start, cmd.commit, cmd.load}))
      else $error("conflicting datapath commands");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid) else $error("commit without result beat");
endmodule
